// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, internal command codes, back-end states and field widths.
// ----------------------------------------------------------------------------
package rau_pkg;

   // Operand width default and fixed result field widths
   localparam int OPERAND_BITS_DEFAULT = 16;
   localparam int KIND_BITS            = 3;
   localparam int NUM_BITS             = 34;
   localparam int DEN_BITS             = 31;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Products formed per item by the shared multiplier
   localparam int MUL_STEPS = 3;

   // Operation codes on the request port
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_CMP = 3'd4
   } kind_type;

   // Command handed from front to back after classification
   localparam int CMD_BITS = 3;
   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_CMP = 3'd4,
      CMD_ERR = 3'd5
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BST_IDLE = 3'd0,
      BST_MUL  = 3'd1,
      BST_FORM = 3'd2,
      BST_NORM = 3'd3,
      BST_GCD  = 3'd4,
      BST_DIV  = 3'd5,
      BST_DONE = 3'd6
   } bst_type;

endpackage

// ===== rtl/core/rau_front.sv =====
// ----------------------------------------------------------------------------
// rau_front: request intake and classification
// Registers one request, decodes its operation and flags bad requests
// (unknown operation or zero denominator) before it enters the queue.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; #(
   parameter int  OPERAND_BITS = OPERAND_BITS_DEFAULT,
   localparam int ENTRY_BITS   = CMD_BITS + 4 * OPERAND_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [KIND_BITS-1:0]           req_kind,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   output logic                           ent_valid,
   input  logic                           ent_ready,
   output logic [ENTRY_BITS-1:0]          ent_data
);

   logic                  valid_ff, valid_in;
   logic [ENTRY_BITS-1:0] data_ff, data_in;
   cmd_type               cmd;

   // Decode operation; a zero denominator overrides everything
   always_comb begin
      case (req_kind)
         KIND_ADD: cmd = CMD_ADD;
         KIND_SUB: cmd = CMD_SUB;
         KIND_MUL: cmd = CMD_MUL;
         KIND_DIV: cmd = CMD_DIV;
         KIND_CMP: cmd = CMD_CMP;
         default:  cmd = CMD_ERR;
      endcase
      if (req_a_den == '0 || req_b_den == '0) begin
         cmd = CMD_ERR;
      end
   end

   assign req_ready = !valid_ff || ent_ready;

   // Holding register toward the queue
   always_comb begin
      valid_in = valid_ff && !ent_ready;
      data_in  = data_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
         data_in  = {cmd, req_a_num, req_a_den, req_b_num, req_b_den};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign ent_valid = valid_ff;
   assign ent_data  = data_ff;

endmodule

// ===== rtl/core/rau_queue.sv =====
// ----------------------------------------------------------------------------
// rau_queue: short item queue between front and back
// Circular buffer with valid/ready on both sides so each side stalls alone.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; #(
   parameter int DATA_BITS = CMD_BITS + 4 * OPERAND_BITS_DEFAULT,
   parameter int DEPTH     = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/rau_back.sv =====
// ----------------------------------------------------------------------------
// rau_back: execution sequencer
// Forms cross products on one shared multiplier, normalizes the sign, finds
// the odd part of the gcd by the binary method (common factors of two are
// stripped from the result as they are found) and divides both terms by it
// with two restoring dividers. Ends in the result register.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; #(
   parameter int  OPERAND_BITS = OPERAND_BITS_DEFAULT,
   localparam int ENTRY_BITS   = CMD_BITS + 4 * OPERAND_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       ent_valid,
   output logic                       ent_ready,
   input  logic [ENTRY_BITS-1:0]      ent_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [NUM_BITS-1:0] rsp_res_num,
   output logic [DEN_BITS-1:0]        rsp_res_den,
   output logic                       rsp_less,
   output logic                       rsp_bad
);

   localparam int OB        = OPERAND_BITS;
   localparam int PW        = 2 * OB;
   localparam int W         = (PW + 1 > 64) ? 64 : PW + 1;
   localparam int W1        = W + 1;
   localparam int CNT_BITS  = $clog2(W);
   localparam int NEXT      = (W > NUM_BITS) ? W : NUM_BITS;
   localparam int DEXT      = (W > DEN_BITS) ? W : DEN_BITS;
   localparam int STEP_BITS = $clog2(MUL_STEPS);

   // Queue entry fields
   cmd_type              ent_cmd;
   logic signed [OB-1:0] ent_an, ent_ad, ent_bn, ent_bd;

   assign ent_cmd = cmd_type'(ent_data[ENTRY_BITS-1 -: CMD_BITS]);
   assign ent_an  = ent_data[4*OB-1 -: OB];
   assign ent_ad  = ent_data[3*OB-1 -: OB];
   assign ent_bn  = ent_data[2*OB-1 -: OB];
   assign ent_bd  = ent_data[OB-1 -: OB];

   // Sequencer and datapath registers
   bst_type              state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic signed [OB-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic signed [PW-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic signed [W-1:0]  num_ff, num_in;
   logic signed [PW-1:0] den_ff, den_in;
   logic [W-1:0]         u_ff, u_in, v_ff, v_in;
   logic [W-1:0]         xm_ff, xm_in, xd_ff, xd_in;
   logic [W-1:0]         rm_ff, rm_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 neg_ff, neg_in, less_ff, less_in, bad_ff, bad_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [NUM_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_BITS-1:0]        rsp_den_ff, rsp_den_in;
   logic                       rsp_less_ff, rsp_less_in;
   logic                       rsp_bad_ff, rsp_bad_in;

   // Shared multiplier: step 0 left numerator term, step 1 cross term,
   // step 2 product of denominators
   logic signed [OB-1:0] ma, mb;
   logic signed [PW-1:0] prod;

   assign ma   = (step_ff == '0) ? an_ff : ad_ff;
   assign mb   = (step_ff == STEP_BITS'(MUL_STEPS - 1)) ? bd_ff :
                 ((step_ff == '0 && cmd_ff != CMD_MUL) ? bd_ff : bn_ff);
   assign prod = ma * mb;

   // Exact compare: flip the test when the denominators differ in sign
   logic less_cmp;
   assign less_cmp = (ad_ff[OB-1] ^ bd_ff[OB-1]) ? (p1_ff < p0_ff) : (p0_ff < p1_ff);

   // Raw numerator and denominator
   logic signed [W-1:0]  wp0, wp1, sum;
   logic signed [PW-1:0] den_sel;

   assign wp0     = W'(p0_ff);
   assign wp1     = W'(p1_ff);
   assign sum     = (cmd_ff == CMD_ADD) ? wp0 + wp1 :
                    (cmd_ff == CMD_SUB) ? wp0 - wp1 : wp0;
   assign den_sel = (cmd_ff == CMD_DIV) ? p1_ff : p2_ff;

   // Sign normalization: move the denominator sign onto the numerator
   logic                 den_neg, neg_n;
   logic [W-1:0]         nn, mag, dmag;
   logic [PW-1:0]        dabs;

   assign den_neg = den_ff[PW-1];
   assign nn      = -num_ff;
   assign neg_n   = den_neg ? nn[W-1] : num_ff[W-1];
   assign mag     = (neg_n ^ den_neg) ? nn : num_ff;
   assign dabs    = den_neg ? PW'(-den_ff) : den_ff;
   assign dmag    = W'(dabs);

   // Binary gcd step terms
   logic [W-1:0] diff_uv, diff_vu;

   assign diff_uv = u_ff - v_ff;
   assign diff_vu = v_ff - u_ff;

   // Restoring divide step for both terms, divisor is the odd gcd part
   logic [W1-1:0] tm, td, sm, sd, dv;
   logic          ge_m, ge_d;

   assign dv   = {1'b0, u_ff};
   assign tm   = {rm_ff, xm_ff[W-1]};
   assign td   = {rd_ff, xd_ff[W-1]};
   assign sm   = tm - dv;
   assign sd   = td - dv;
   assign ge_m = !sm[W];
   assign ge_d = !sd[W];

   // Final sign and resize to the result fields
   logic signed [W-1:0]    num_fin;
   logic signed [NEXT-1:0] num_ext;
   logic [DEXT-1:0]        den_ext;

   assign num_fin = neg_ff ? -xm_ff : xm_ff;
   assign num_ext = NEXT'(num_fin);
   assign den_ext = DEXT'(xd_ff);

   assign ent_ready = (state_ff == BST_IDLE);

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      step_in      = step_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      xm_in        = xm_ff;
      xd_in        = xd_ff;
      rm_in        = rm_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      less_in      = less_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_less_in  = rsp_less_ff;
      rsp_bad_in   = rsp_bad_ff;

      case (state_ff)
         // Take the next item from the queue
         BST_IDLE: begin
            if (ent_valid) begin
               cmd_in  = ent_cmd;
               an_in   = ent_an;
               ad_in   = ent_ad;
               bn_in   = ent_bn;
               bd_in   = ent_bd;
               step_in = '0;
               neg_in  = 1'b0;
               less_in = 1'b0;
               bad_in  = 1'b0;
               if (ent_cmd == CMD_ERR) begin
                  bad_in   = 1'b1;
                  xm_in    = '0;
                  xd_in    = '0;
                  state_in = BST_DONE;
               end else begin
                  state_in = BST_MUL;
               end
            end
         end

         // One product per cycle
         BST_MUL: begin
            if (step_ff == '0) begin
               p0_in = prod;
            end else if (step_ff == STEP_BITS'(1)) begin
               p1_in = prod;
            end else begin
               p2_in = prod;
            end
            if (step_ff == STEP_BITS'(MUL_STEPS - 1)) begin
               state_in = BST_FORM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         // Compare result, or raw fraction with zero-denominator check
         BST_FORM: begin
            if (cmd_ff == CMD_CMP) begin
               less_in  = less_cmp;
               xm_in    = '0;
               xd_in    = W'(1);
               state_in = BST_DONE;
            end else if (den_sel == '0) begin
               bad_in   = 1'b1;
               xm_in    = '0;
               xd_in    = '0;
               state_in = BST_DONE;
            end else begin
               num_in   = sum;
               den_in   = den_sel;
               state_in = BST_NORM;
            end
         end

         // Magnitudes; zero numerator goes out as 0/1
         BST_NORM: begin
            neg_in = neg_n;
            u_in   = mag;
            v_in   = dmag;
            xm_in  = mag;
            xd_in  = dmag;
            if (mag == '0) begin
               neg_in   = 1'b0;
               xd_in    = W'(1);
               state_in = BST_DONE;
            end else begin
               state_in = BST_GCD;
            end
         end

         // Binary gcd; shared factors of two come off the result at once
         BST_GCD: begin
            if (u_ff == v_ff) begin
               if (u_ff == W'(1)) begin
                  state_in = BST_DONE;
               end else begin
                  rm_in    = '0;
                  rd_in    = '0;
                  cnt_in   = '0;
                  state_in = BST_DIV;
               end
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in  = u_ff >> 1;
               v_in  = v_ff >> 1;
               xm_in = xm_ff >> 1;
               xd_in = xd_ff >> 1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = diff_uv >> 1;
            end else begin
               v_in = diff_vu >> 1;
            end
         end

         // One quotient bit per cycle for both terms
         BST_DIV: begin
            xm_in = {xm_ff[W-2:0], ge_m};
            xd_in = {xd_ff[W-2:0], ge_d};
            rm_in = ge_m ? sm[W-1:0] : tm[W-1:0];
            rd_in = ge_d ? sd[W-1:0] : td[W-1:0];
            if (cnt_ff == CNT_BITS'(W - 1)) begin
               state_in = BST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Hand over to the result register when it is free
         BST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ext[NUM_BITS-1:0];
               rsp_den_in   = den_ext[DEN_BITS-1:0];
               rsp_less_in  = less_ff;
               rsp_bad_in   = bad_ff;
               state_in     = BST_IDLE;
            end
         end

         default: begin
            state_in = BST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      bn_ff       <= bn_in;
      bd_ff       <= bd_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      xm_ff       <= xm_in;
      xd_ff       <= xd_in;
      rm_ff       <= rm_in;
      rd_ff       <= rd_in;
      neg_ff      <= neg_in;
      less_ff     <= less_in;
      bad_ff      <= bad_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_less_ff <= rsp_less_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_less    = rsp_less_ff;
   assign rsp_bad     = rsp_bad_ff;

`ifndef SYNTHESIS
   // gcd operands never reach zero
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BST_GCD) |-> (u_ff != '0 && v_ff != '0))
      else $error("gcd operand reached zero");

   // division by the gcd part leaves no remainder
   a_div_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BST_DIV && cnt_ff == CNT_BITS'(W - 1)) |=> (rm_ff == '0 && rd_ff == '0))
      else $error("reduction left a remainder");

   // error results carry an empty fraction
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_num_ff == '0 && rsp_den_ff == '0 && !rsp_less_ff))
      else $error("error result with nonzero fields");

   // compare results are 0/1 with the flag
   a_less_frac: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_less_ff) |-> (rsp_num_ff == '0 && rsp_den_ff == DEN_BITS'(1)))
      else $error("compare result fraction is not 0/1");
`endif

endmodule

// ===== rtl/core/rational_arithmetic_unit_core.sv =====
// Path: intake register, queue, then 3 products, form, normalize, gcd steps and,
// unless the odd gcd part is 1, W divide steps, then the result register
// (W = 2*OPERAND_BITS+1, at most 64; W = 33 at the default width).
// Compares and zero numerators skip the gcd and divide steps; intake errors skip all steps.
// The back end takes a new item only once the last is in the result register.
// Reset: synchronous, active high; empties the queue and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: exact arithmetic on two signed fractions
// Add, subtract, multiply, divide and compare with gcd-reduced results.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core import rau_pkg::*; #(
   parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [KIND_BITS-1:0]           req_kind,
   input  logic signed [OPERAND_BITS-1:0] req_a_num,
   input  logic signed [OPERAND_BITS-1:0] req_a_den,
   input  logic signed [OPERAND_BITS-1:0] req_b_num,
   input  logic signed [OPERAND_BITS-1:0] req_b_den,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [NUM_BITS-1:0]     rsp_res_num,
   output logic [DEN_BITS-1:0]            rsp_res_den,
   output logic                           rsp_less,
   output logic                           rsp_bad
);

   localparam int ENTRY_BITS = CMD_BITS + 4 * OPERAND_BITS;

   logic                  fq_valid, fq_ready;
   logic [ENTRY_BITS-1:0] fq_data;
   logic                  qb_valid, qb_ready;
   logic [ENTRY_BITS-1:0] qb_data;

   // Intake and classification
   rau_front #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .ent_valid (fq_valid),
      .ent_ready (fq_ready),
      .ent_data  (fq_data)
   );

   // Decoupling queue
   rau_queue #(
      .DATA_BITS (ENTRY_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // Execution
   rau_back #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .ent_valid   (qb_valid),
      .ent_ready   (qb_ready),
      .ent_data    (qb_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_less    (rsp_less),
      .rsp_bad     (rsp_bad)
   );

endmodule
